>>> design/tdpc_pkg.sv
// shared types and constants for the trial division prime counter
// no dependencies; imported by every module of the block
package tdpc_pkg;

   localparam int NumberWidth  = 32;
   localparam int CountWidth   = 32;
   localparam int DivisorWidth = 17;
   localparam int RemWidth     = DivisorWidth - 1;
   localparam int SquareWidth  = 2 * DivisorWidth;
   localparam int BitIdxWidth  = $clog2(NumberWidth);

   localparam logic [DivisorWidth-1:0] DivisorStart = DivisorWidth'(3);
   localparam logic [DivisorWidth-1:0] DivisorStep  = DivisorWidth'(2);
   localparam logic [SquareWidth-1:0]  SquareStart  = SquareWidth'(9);
   localparam logic [NumberWidth-1:0]  SmallestOdd  = NumberWidth'(3);
   localparam logic [NumberWidth-1:0]  OnlyEvenPrime = NumberWidth'(2);
   localparam logic [CountWidth-1:0]   CountMax     = {CountWidth{1'b1}};

   typedef struct packed {
      logic [31:0] candidate;
      logic        range_last;
   } req_type;

   typedef struct packed {
      logic        is_prime;
      logic [31:0] prime_count;
      logic        range_done;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic advance;
      logic emit;
      logic verdict;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trivial;
      logic trivial_prime;
      logic bound_ok;
      logic div_last;
      logic rem_zero;
   } status_type;

endpackage

>>> design/tdpc_ctrl.sv
// sequencing state machine of the trial division prime counter
// depends on tdpc_pkg; drives the datapath in tdpc_dp by command struct
module tdpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tdpc_pkg::status_type status,
   output tdpc_pkg::cmd_type    cmd
);
   import tdpc_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      CLASSIFY,
      BOUND,
      DIV,
      REM,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      verdict_in  = verdict_ff;
      cmd         = '0;
      cmd.verdict = verdict_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CLASSIFY;
            end
         end
         CLASSIFY: begin
            if (status.trivial) begin
               verdict_in = status.trivial_prime;
               state_in   = FINISH;
            end else begin
               state_in = BOUND;
            end
         end
         BOUND: begin
            if (status.bound_ok) begin
               cmd.div_start = 1'b1;
               state_in      = DIV;
            end else begin
               verdict_in = 1'b1;
               state_in   = FINISH;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = REM;
            end
         end
         REM: begin
            if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = BOUND;
            end
         end
         FINISH: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result emitted over an untaken result");

   a_div_ends_in_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV && status.div_last) |=> (state_ff == REM))
      else $error("division did not end in remainder check");

   a_accept_starts_classify: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == CLASSIFY))
      else $error("accepted request did not start classification");
`endif

endmodule

>>> design/tdpc_dp.sv
// datapath: candidate, trial divisor and its square, bit-serial remainder,
// range count and result register; depends on tdpc_pkg
module tdpc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tdpc_pkg::req_type    req_data,
   input  tdpc_pkg::cmd_type    cmd,
   output tdpc_pkg::status_type status,
   output tdpc_pkg::rsp_type    rsp_data
);
   import tdpc_pkg::*;

   logic [NumberWidth-1:0]  cand_ff;
   logic                    last_ff;
   logic [DivisorWidth-1:0] divisor_ff;
   logic [SquareWidth-1:0]  square_ff;
   logic [RemWidth-1:0]     rem_ff, rem_in;
   logic [BitIdxWidth-1:0]  idx_ff;
   logic [CountWidth-1:0]   count_ff, count_in;
   rsp_type                 out_ff;

   logic [DivisorWidth-1:0] trial;
   logic [DivisorWidth-1:0] trial_diff;

   // one restoring division step: bring down the next candidate bit
   assign trial      = {rem_ff, cand_ff[idx_ff]};
   assign trial_diff = trial - divisor_ff;
   assign rem_in     = (trial >= divisor_ff) ? trial_diff[RemWidth-1:0]
                                             : trial[RemWidth-1:0];

   assign status.trivial       = (cand_ff < SmallestOdd) || !cand_ff[0];
   assign status.trivial_prime = (cand_ff == OnlyEvenPrime);
   assign status.bound_ok      = (square_ff <= SquareWidth'(cand_ff));
   assign status.div_last      = (idx_ff == '0);
   assign status.rem_zero      = (rem_ff == '0);

   // saturating count including this item
   assign count_in = (cmd.verdict && count_ff != CountMax) ? count_ff + 1'b1 : count_ff;

   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cand_ff    <= req_data.candidate[NumberWidth-1:0];
         last_ff    <= req_data.range_last;
         divisor_ff <= DivisorStart;
         square_ff  <= SquareStart;
      end
      if (cmd.advance) begin
         // (d + 2)^2 = d^2 + 4d + 4
         divisor_ff <= divisor_ff + DivisorStep;
         square_ff  <= square_ff + (SquareWidth'(divisor_ff) << 2) + SquareWidth'(4);
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         idx_ff <= BitIdxWidth'(NumberWidth - 1);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         idx_ff <= idx_ff - 1'b1;
      end
      if (cmd.emit) begin
         out_ff.is_prime    <= cmd.verdict;
         out_ff.prime_count <= count_in;
         out_ff.range_done  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.emit) begin
         count_ff <= last_ff ? '0 : count_in;
      end
   end

`ifndef SYNTH
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (DivisorWidth'(rem_ff) < divisor_ff))
      else $error("remainder not below divisor");

   a_square_tracks_divisor: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.advance) |=>
         (square_ff == SquareWidth'(SquareWidth'(divisor_ff) * SquareWidth'(divisor_ff))))
      else $error("square out of step with divisor");
`endif

endmodule

>>> design/trial_division_prime_counter.sv
// top level of the trial division prime counter
// depends on tdpc_pkg, tdpc_ctrl and tdpc_dp
module trial_division_prime_counter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tdpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tdpc_pkg::rsp_type rsp_data
);
   // tests one 32-bit unsigned candidate per request for primality and
   // returns one response with the prime flag, the running prime count of
   // the current range (saturating at all ones) and range_done, a copy of
   // range_last; the count clears after the response that closes a range.
   // numbers below 2 and even numbers other than 2 are settled without a trial
   // divisor. an odd candidate tries odd divisors 3, 5, 7, ... while d*d stays
   // at or below it; each trial is a bound check, a 32-step bit-serial
   // remainder and a zero check, so the work per item grows with the number
   // of trial divisors. the single remainder unit handles one bit per cycle.
   // one request is in work at a time; the response register lets the next
   // request in while the previous response waits to be taken.
   import tdpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: accept, classify, bound/divide loop, emit
   tdpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // divisor, square, remainder, count and response register
   tdpc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> verif/trial_division_prime_counter_tb.sv
// self-checking testbench for the trial division prime counter
// depends on tdpc_pkg and the trial_division_prime_counter rtl only
`timescale 1ns / 100ps

module trial_division_prime_counter_tb;

   import tdpc_pkg::*;

   // cycles with no request and no response accepted before we give up;
   // the slowest candidate here (a prime near 2^24) needs ~2k trial divisors
   localparam int StallLimit  = 1000000;
   // long receiver hold-off used to back the block up
   localparam int HoldCycles  = 500;
   // settle time after the last response, block should be quiet by then
   localparam int DrainCycles = 200;
   localparam int RandomPerPhase = 36;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // requests waiting to be offered, and verdicts waiting to come back
   req_type candidate_queue[$];
   rsp_type expected_verdicts[$];

   // predictor state: running prime total of the open range
   logic [CountWidth-1:0] primes_in_range = '0;

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   trial_division_prime_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // plain trial division over odd divisors, bound written as d <= n / d
   function automatic bit number_is_prime(logic [NumberWidth-1:0] value);
      longint unsigned n;
      longint unsigned d;
      n = value;
      if (n <= 1) return 1'b0;
      if (n == 2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // expected response for one accepted request; advances the range total
   function automatic rsp_type predict_verdict(req_type req);
      rsp_type verdict;
      verdict.is_prime = number_is_prime(req.candidate);
      // count saturates at all ones until the range closes
      if (verdict.is_prime && primes_in_range != CountMax) begin
         primes_in_range = primes_in_range + 1'b1;
      end
      verdict.prime_count = primes_in_range;
      verdict.range_done  = req.range_last;
      // closing request clears the total for the next range
      if (req.range_last) primes_in_range = '0;
      return verdict;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_candidate(input logic [31:0] number, input bit last);
      req_type req;
      req.candidate  = number;
      req.range_last = last;
      candidate_queue.push_back(req);
   endtask

   // sender pause: nothing new until every expected response is back
   task automatic wait_until_drained();
      while (candidate_queue.size() != 0 || req_valid || expected_verdicts.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // mostly small numbers so primes stay cheap; wide numbers carry a small
   // factor so the divide loop exits early
   function automatic logic [31:0] random_candidate();
      int unsigned pick;
      int unsigned factor;
      logic [31:0] quotient;
      pick = $urandom_range(99);
      if (pick < 60) return 32'($urandom_range(4095));
      if (pick < 80) return 32'($urandom_range(65535));
      if (pick < 90) return $urandom & 32'hFFFF_FFFE;
      case ($urandom_range(2))
         0: factor = 3;
         1: factor = 5;
         default: factor = 7;
      endcase
      quotient = $urandom % (32'hFFFF_FFFF / factor);
      return quotient * factor;
   endfunction

   // driver: offers queued requests, predicts each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(predict_verdict(req_data));
         end
         // a held request stays put until the block takes it
         if (!req_valid || req_ready) begin
            if (candidate_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= candidate_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, plus long hold-offs when asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HoldCycles;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: every accepted response against the oldest prediction
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("response with none pending: %p", rsp_data));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.is_prime !== want.is_prime) begin
               report_mismatch($sformatf("is_prime got %b want %b",
                                         rsp_data.is_prime, want.is_prime));
            end
            if (rsp_data.prime_count !== want.prime_count) begin
               report_mismatch($sformatf("prime_count got %0d want %0d",
                                         rsp_data.prime_count, want.prime_count));
            end
            if (rsp_data.range_done !== want.range_done) begin
               report_mismatch($sformatf("range_done got %b want %b",
                                         rsp_data.range_done, want.range_done));
            end
         end
      end
   end

   // watchdog: too long with neither channel moving means a hang
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles often, receiver more
      send_idle_pct = 30;
      recv_idle_pct = 54;

      // smallest values, the only even prime, first odd primes
      queue_candidate(32'd0, 1'b0);
      queue_candidate(32'd1, 1'b0);
      queue_candidate(32'd2, 1'b0);
      queue_candidate(32'd3, 1'b0);
      queue_candidate(32'd4, 1'b1);
      // odd squares sit right on the divisor bound
      queue_candidate(32'd5, 1'b0);
      queue_candidate(32'd9, 1'b0);
      queue_candidate(32'd25, 1'b0);
      queue_candidate(32'd49, 1'b0);
      queue_candidate(32'd121, 1'b0);
      queue_candidate(32'd15, 1'b0);
      queue_candidate(32'd97, 1'b1);
      // a range of one prime, then one of one composite
      queue_candidate(32'd7, 1'b1);
      queue_candidate(32'd8, 1'b1);
      // largest 16-bit prime, semiprime of two close primes, prime near 2^24
      queue_candidate(32'd65521, 1'b0);
      queue_candidate(32'd1022117, 1'b0);
      queue_candidate(32'd16777213, 1'b0);
      // wide values: all ones, all ones minus one, top bit alone, stripes
      queue_candidate(32'hFFFF_FFFF, 1'b0);
      queue_candidate(32'hFFFF_FFFE, 1'b0);
      queue_candidate(32'h8000_0000, 1'b0);
      queue_candidate(32'h5555_5555, 1'b0);
      queue_candidate(32'hAAAA_AAAA, 1'b0);
      queue_candidate(32'd13, 1'b1);
      wait_until_drained();

      // back-pressure: receiver holds off while cheap requests keep coming
      holds_asked = holds_asked + 1;
      for (int i = 0; i < 12; i++) begin
         queue_candidate((i % 3 == 0) ? 32'd11 : ($urandom & 32'hFFFF_FFFE), i == 11);
      end
      wait_until_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < RandomPerPhase; i++) begin
            queue_candidate(random_candidate(), $urandom_range(7) == 0);
         end
         wait_until_drained();
      end

      // let any stray response show up before the verdict
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
